// File: hdl/dtsc_pkg.sv
// ----------------------------------------------------------------------------
// dtsc_pkg
// Shared types and constants of the debounced light and fan switch controller.
// ----------------------------------------------------------------------------
package dtsc_pkg;

  localparam int TIME_W = 32;
  localparam int DEB_W  = 16;
  localparam int WIN_W  = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Opcodes of an input beat.
  localparam logic OP_POLL   = 1'b0;
  localparam logic OP_REMOTE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO_WINDOW  = 2'd2;

  // Register reset values.
  localparam logic [DEB_W-1:0] DEBOUNCE_MIN_RST = 16'd10;
  localparam logic [WIN_W-1:0] LOCKOUT_RST      = 20'd2000;
  localparam logic [WIN_W-1:0] PRIO_WINDOW_RST  = 20'd10000;

  // A lockout deadline that has not been set yet.
  localparam logic [TIME_W-1:0] LOCKOUT_END_RST = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [DEB_W-1:0] min_hold_ms;
    logic [WIN_W-1:0] lock_time_ms;
    logic [WIN_W-1:0] priority_window_ms;
  } cfg_t;

endpackage

// File: hdl/dtsc_debounce.sv
// ----------------------------------------------------------------------------
// dtsc_debounce
// Debounce and lockout tracker for one push button.
// ----------------------------------------------------------------------------
module dtsc_debounce (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      upd,
  input  logic                      down,
  input  logic [dtsc_pkg::TIME_W-1:0] now,
  input  dtsc_pkg::cfg_t            cfg,
  output logic                      press
);
  import dtsc_pkg::*;

  logic              prev_released;
  logic              armed;
  logic [TIME_W-1:0] down_time;
  logic [TIME_W-1:0] lockout_end;

  logic [TIME_W-1:0] lock_diff;
  logic [TIME_W-1:0] held;
  logic              arm;
  logic              release_seen;

  assign lock_diff = now - lockout_end;
  assign held      = now - down_time;

  // The lockout has run out when the wrapped distance past its end is below
  // half the time range.
  assign arm          = down && prev_released && !armed && !lock_diff[TIME_W-1];
  assign release_seen = armed && !down;
  assign press        = release_seen && !prev_released &&
                        (held >= {{(TIME_W-DEB_W){1'b0}}, cfg.min_hold_ms});

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_released <= 1'b1;
      armed         <= 1'b0;
      down_time     <= '0;
      lockout_end   <= LOCKOUT_END_RST;
    end else if (upd) begin
      prev_released <= !down;
      if (arm) begin
        armed     <= 1'b1;
        down_time <= now;
      end else if (release_seen) begin
        armed <= 1'b0;
      end
      if (press) begin
        lockout_end <= now + {{(TIME_W-WIN_W){1'b0}}, cfg.lock_time_ms};
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    upd && press |=> !armed && lockout_end == $past(now + {12'd0, cfg.lock_time_ms}))
    else $error("counted press did not start the lockout");

  assert property (@(posedge clk) disable iff (rst)
    upd && arm |=> armed && down_time == $past(now) && !prev_released)
    else $error("arming did not record the press time");

  assert property (@(posedge clk) disable iff (rst)
    !upd |=> $stable(armed) && $stable(lockout_end) && $stable(prev_released))
    else $error("debounce state changed without a poll");

endmodule

// File: hdl/debounced_toggle_switch_controller_unit.sv
// ----------------------------------------------------------------------------
// debounced_toggle_switch_controller_unit
// Light and fan controller with two debounced push buttons and remote control.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one beat per button poll or
//   remote light command; the output channel (out_valid/out_ready) returns one
//   result beat per input beat, in order.
//   A beat is captured in an input register, evaluated by the two debounce
//   trackers and the light/fan logic, and lands in the result register.
//   Throughput is one beat per cycle while out_ready stays high, set by the
//   single evaluation stage between the input and result registers.
//   When the receiver stalls, the result register holds and the input
//   register can still take one more beat; after that in_ready drops.
//   The cfg_wr_en/cfg_index/cfg_data port writes a register while cfg_wr_en is high;
//   indexes beyond the register list are ignored. Write it only while idle.
//   Reset (rst, synchronous) empties both registers, restores the register
//   defaults and returns the light, fan and debounce state to idle.
// ----------------------------------------------------------------------------
module debounced_toggle_switch_controller_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [dtsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dtsc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             opcode,
  input  logic [dtsc_pkg::TIME_W-1:0]      now_ms,
  input  logic                             light_button_down,
  input  logic                             fan_button_down,
  input  logic                             lux_active,
  input  logic                             drive_fan_pin,
  input  logic                             remote_lamp_on,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             lamp_on,
  output logic                             fan_on,
  output logic                             fan_drive,
  output logic                             light_press_seen,
  output logic                             fan_press_seen
);
  import dtsc_pkg::*;

  cfg_t cfg;

  // Input register.
  logic              s1_valid;
  logic              s1_opcode;
  logic [TIME_W-1:0] s1_now_ms;
  logic              s1_light_down;
  logic              s1_fan_down;
  logic              s1_lux;
  logic              s1_drive;
  logic              s1_remote_on;

  // Controller state.
  logic              light_state;
  logic              fan_state;
  logic              fan_drive_state;
  logic [TIME_W-1:0] remote_off_time;
  logic              remote_off_valid;

  logic              advance;
  logic              poll;
  logic              lp;
  logic              fp;
  logic              lp_raw;
  logic              fp_raw;
  logic [TIME_W-1:0] since_off;
  logic              in_window;
  logic              light_state_next;
  logic              fan_state_next;
  logic              fan_drive_state_next;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign poll     = (s1_opcode == OP_POLL);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_hold_ms        <= DEBOUNCE_MIN_RST;
      cfg.lock_time_ms       <= LOCKOUT_RST;
      cfg.priority_window_ms <= PRIO_WINDOW_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEBOUNCE_MIN: cfg.min_hold_ms        <= cfg_data[DEB_W-1:0];
        REG_LOCKOUT:      cfg.lock_time_ms       <= cfg_data[WIN_W-1:0];
        REG_PRIO_WINDOW:  cfg.priority_window_ms <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode     <= opcode;
      s1_now_ms     <= now_ms;
      s1_light_down <= light_button_down;
      s1_fan_down   <= fan_button_down;
      s1_lux        <= lux_active;
      s1_drive      <= drive_fan_pin;
      s1_remote_on  <= remote_lamp_on;
    end
  end

  dtsc_debounce u_light_deb (
    .clk   (clk),
    .rst   (rst),
    .upd   (advance && poll),
    .down  (s1_light_down),
    .now   (s1_now_ms),
    .cfg   (cfg),
    .press (lp_raw)
  );

  dtsc_debounce u_fan_deb (
    .clk   (clk),
    .rst   (rst),
    .upd   (advance && poll),
    .down  (s1_fan_down),
    .now   (s1_now_ms),
    .cfg   (cfg),
    .press (fp_raw)
  );

  assign lp = poll && lp_raw;
  assign fp = poll && fp_raw;

  assign since_off = s1_now_ms - remote_off_time;
  assign in_window = remote_off_valid &&
                     (since_off <= {{(TIME_W-WIN_W){1'b0}}, cfg.priority_window_ms});

  always_comb begin
    light_state_next     = light_state;
    fan_state_next       = fan_state;
    fan_drive_state_next = fan_drive_state;
    if (poll) begin
      if (fp) begin
        fan_state_next = !fan_state;
        if (s1_drive) begin
          fan_drive_state_next = !fan_state;
        end
      end
      if (lp) begin
        // A recent remote off-command turns a light press into a plain off.
        if (in_window) begin
          light_state_next = 1'b0;
        end else if (!light_state) begin
          light_state_next = !s1_lux;
        end else begin
          light_state_next = 1'b0;
        end
      end
    end else begin
      light_state_next = s1_remote_on;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      light_state      <= 1'b0;
      fan_state        <= 1'b0;
      fan_drive_state  <= 1'b0;
      remote_off_time  <= '0;
      remote_off_valid <= 1'b0;
    end else if (advance) begin
      light_state     <= light_state_next;
      fan_state       <= fan_state_next;
      fan_drive_state <= fan_drive_state_next;
      if (s1_opcode == OP_REMOTE && !s1_remote_on) begin
        remote_off_time  <= s1_now_ms;
        remote_off_valid <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lamp_on          <= light_state_next;
      fan_on           <= fan_state_next;
      fan_drive        <= fan_drive_state_next;
      light_press_seen <= lp;
      fan_press_seen   <= fp;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    advance |=> lamp_on == light_state && fan_on == fan_state &&
                fan_drive == fan_drive_state)
    else $error("result beat disagrees with controller state");

  assert property (@(posedge clk) disable iff (rst)
    advance && s1_opcode == OP_REMOTE |=> !light_press_seen && !fan_press_seen)
    else $error("press reported on a remote command beat");

  assert property (@(posedge clk) disable iff (rst)
    advance && s1_opcode == OP_REMOTE && !s1_remote_on |=>
      remote_off_valid && !light_state && remote_off_time == $past(s1_now_ms))
    else $error("remote off-command did not open the priority window");

  assert property (@(posedge clk) disable iff (rst)
    advance && !s1_drive |=> fan_drive_state == $past(fan_drive_state))
    else $error("fan drive changed without drive enable");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the debounced light and fan switch controller.
// A directed table steps through debounce, lockout, lux blocking, fan drive
// and the remote-off priority window. Random button sequences then run under
// several register settings and handshake idling patterns. Every result beat
// is checked field by field against its table row or the behavioral model.
// ----------------------------------------------------------------------------
module tb_top;
  import dtsc_pkg::*;

  localparam int unsigned IDLE_LIMIT      = 3000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int          NUM_PHASES      = 6;
  localparam logic [TIME_W-1:0] HALF_RANGE = 32'h8000_0000;
  // The fourth index has no register behind it; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic              opcode;
    logic [TIME_W-1:0] now_ms;
    logic              light_down;
    logic              fan_down;
    logic              lux;
    logic              drive_fan;
    logic              remote_on;
  } beat_t;

  typedef struct packed {
    logic lamp_on;
    logic fan_on;
    logic fan_drive;
    logic light_press;
    logic fan_press;
  } status_t;

  // pins are {light_down, fan_down, lux, drive_fan, remote_on}.
  typedef struct packed {
    logic              opcode;
    logic [TIME_W-1:0] now_ms;
    logic [4:0]        pins;
    logic              checked;
    status_t           status;
  } dir_row_t;

  typedef struct packed {
    logic              released;
    logic              armed;
    logic [TIME_W-1:0] down_at;
    logic [TIME_W-1:0] lockout_end;
  } button_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  opcode;
  logic [TIME_W-1:0]     now_ms;
  logic                  light_button_down;
  logic                  fan_button_down;
  logic                  lux_active;
  logic                  drive_fan_pin;
  logic                  remote_lamp_on;
  logic                  out_valid;
  logic                  out_ready;
  logic                  lamp_on;
  logic                  fan_on;
  logic                  fan_drive;
  logic                  light_press_seen;
  logic                  fan_press_seen;

  debounced_toggle_switch_controller_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register mirror and controller state of the model.
  logic [DEB_W-1:0]  m_debounce;
  logic [WIN_W-1:0]  m_lockout;
  logic [WIN_W-1:0]  m_window;
  button_t           light_btn;
  button_t           fan_btn;
  logic              light_st;
  logic              fan_st;
  logic              fan_drive_st;
  logic              remote_off_seen;
  logic [TIME_W-1:0] remote_off_at;

  status_t     pending_status [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_beats = 0;
  int unsigned n_results = 0;
  int unsigned n_light_presses = 0;
  int unsigned n_fan_presses = 0;
  int unsigned n_errors = 0;

  // Random stimulus keeps its own wall clock and button levels so that most
  // polls form real press and release sequences.
  logic [TIME_W-1:0] sim_now = '0;
  logic              light_lvl = 1'b0;
  logic              fan_lvl = 1'b0;

  string field_name [5] = '{"fan_press_seen", "light_press_seen", "fan_drive",
                            "fan_on", "lamp_on"};

  // Runs with the reset register values: debounce 10, lockout 2000, window 10000.
  dir_row_t dir_tbl [25] = '{
    '{OP_POLL,   32'd0,     5'b00000, 1'b1, 5'b00000},
    // Remote command ignores the buttons.
    '{OP_REMOTE, 32'd5,     5'b11001, 1'b1, 5'b10000},
    '{OP_POLL,   32'd100,   5'b01010, 1'b1, 5'b10000},
    '{OP_POLL,   32'd200,   5'b01010, 1'b1, 5'b10000},
    '{OP_POLL,   32'd300,   5'b00010, 1'b1, 5'b11101},
    // Fan still locked out, so this press never arms.
    '{OP_POLL,   32'd400,   5'b01010, 1'b1, 5'b11100},
    '{OP_POLL,   32'd500,   5'b00010, 1'b1, 5'b11100},
    // Held only 5 ms: too short to count.
    '{OP_POLL,   32'd3000,  5'b01000, 1'b1, 5'b11100},
    '{OP_POLL,   32'd3005,  5'b00000, 1'b1, 5'b11100},
    // Fan toggles off without drive, so the drive level stays high.
    '{OP_POLL,   32'd3100,  5'b01000, 1'b1, 5'b11100},
    '{OP_POLL,   32'd3200,  5'b00000, 1'b1, 5'b10101},
    '{OP_POLL,   32'd3300,  5'b10000, 1'b1, 5'b10100},
    '{OP_POLL,   32'd3400,  5'b00000, 1'b1, 5'b00110},
    // Lux keeps an off light off.
    '{OP_POLL,   32'd6000,  5'b10100, 1'b1, 5'b00100},
    '{OP_POLL,   32'd6100,  5'b00100, 1'b1, 5'b00110},
    '{OP_POLL,   32'd9000,  5'b10000, 1'b1, 5'b00100},
    '{OP_POLL,   32'd9100,  5'b00000, 1'b1, 5'b10110},
    '{OP_REMOTE, 32'd9200,  5'b00000, 1'b1, 5'b00100},
    '{OP_POLL,   32'd12000, 5'b10000, 1'b1, 5'b00100},
    '{OP_POLL,   32'd12100, 5'b00000, 1'b1, 5'b00110},
    '{OP_REMOTE, 32'd12200, 5'b00001, 1'b1, 5'b10100},
    // Poll ignores the remote value; the press inside the window forces off.
    '{OP_POLL,   32'd15000, 5'b10001, 1'b1, 5'b10100},
    '{OP_POLL,   32'd15100, 5'b00000, 1'b1, 5'b00110},
    '{OP_POLL,   32'hFFFF_FFF0, 5'b11110, 1'b0, 5'b00000},
    '{OP_POLL,   32'hFFFF_FFFF, 5'b00011, 1'b0, 5'b00000}
  };

  function automatic logic track_button(inout button_t t, input logic down,
                                        input logic [TIME_W-1:0] now);
    logic              counted;
    logic [TIME_W-1:0] since_lock;
    logic [TIME_W-1:0] held;
    counted = 1'b0;
    since_lock = now - t.lockout_end;
    if (down && t.released && !t.armed && since_lock < HALF_RANGE) begin
      t.armed = 1'b1;
      t.down_at = now;
    end
    if (t.armed && !down) begin
      held = now - t.down_at;
      if (!t.released && held >= TIME_W'(m_debounce)) begin
        counted = 1'b1;
        t.lockout_end = now + TIME_W'(m_lockout);
      end
      t.armed = 1'b0;
    end
    t.released = !down;
    return counted;
  endfunction

  function automatic status_t predict_status(input beat_t b);
    status_t           s;
    logic [TIME_W-1:0] since_off;
    s = '0;
    if (b.opcode == OP_POLL) begin
      s.fan_press = track_button(fan_btn, b.fan_down, b.now_ms);
      if (s.fan_press) begin
        fan_st = !fan_st;
        if (b.drive_fan) fan_drive_st = fan_st;
      end
      s.light_press = track_button(light_btn, b.light_down, b.now_ms);
      since_off = b.now_ms - remote_off_at;
      if (s.light_press) begin
        if (remote_off_seen && since_off <= TIME_W'(m_window)) light_st = 1'b0;
        else if (!light_st) light_st = !b.lux;
        else light_st = 1'b0;
      end
    end else if (b.remote_on) begin
      light_st = 1'b1;
    end else begin
      light_st = 1'b0;
      remote_off_at = b.now_ms;
      remote_off_seen = 1'b1;
    end
    s.lamp_on = light_st;
    s.fan_on = fan_st;
    s.fan_drive = fan_drive_st;
    return s;
  endfunction

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_DEBOUNCE_MIN: m_debounce = val[DEB_W-1:0];
      REG_LOCKOUT:      m_lockout = val[WIN_W-1:0];
      REG_PRIO_WINDOW:  m_window = val[WIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_beat(input beat_t b, input logic checked,
                           input status_t typed_status);
    status_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {opcode, now_ms, light_button_down, fan_button_down, lux_active,
     drive_fan_pin, remote_lamp_on} <= b;
    do @(posedge clk); while (!in_ready);
    want = predict_status(b);
    n_beats++;
    n_light_presses += 32'(want.light_press);
    n_fan_presses += 32'(want.fan_press);
    pending_status.push_back(checked ? typed_status : want);
  endtask

  task automatic make_random_beat(output beat_t b);
    int unsigned pick;
    int unsigned lock_span;
    int unsigned hold_span;
    lock_span = 32'(m_lockout);
    lock_span += 32'(m_window);
    hold_span = 2 * 32'(m_debounce) + 20;
    pick = $urandom_range(0, 99);
    if (pick < 5) sim_now = $urandom;
    else if (pick < 15) sim_now += $urandom_range(0, 4);
    else if (pick < 40) sim_now += $urandom_range(0, lock_span);
    else sim_now += $urandom_range(0, hold_span);
    b.opcode = ($urandom_range(0, 99) < 12) ? OP_REMOTE : OP_POLL;
    if (b.opcode == OP_POLL) begin
      if ($urandom_range(0, 99) < 40) light_lvl = !light_lvl;
      if ($urandom_range(0, 99) < 40) fan_lvl = !fan_lvl;
      b.light_down = light_lvl;
      b.fan_down = fan_lvl;
    end else begin
      b.light_down = 1'($urandom_range(0, 1));
      b.fan_down = 1'($urandom_range(0, 1));
    end
    b.now_ms = sim_now;
    b.lux = 1'($urandom_range(0, 1));
    b.drive_fan = 1'($urandom_range(0, 1));
    b.remote_on = 1'($urandom_range(0, 1));
  endtask

  initial begin
    beat_t       b;
    int unsigned mode;
    int unsigned n_items;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_DEBOUNCE_MIN;
    cfg_data = '0;
    in_valid = 1'b0;
    {opcode, now_ms, light_button_down, fan_button_down, lux_active,
     drive_fan_pin, remote_lamp_on} = '0;
    m_debounce = DEBOUNCE_MIN_RST;
    m_lockout = LOCKOUT_RST;
    m_window = PRIO_WINDOW_RST;
    light_btn = '{1'b1, 1'b0, '0, LOCKOUT_END_RST};
    fan_btn = '{1'b1, 1'b0, '0, LOCKOUT_END_RST};
    light_st = 1'b0;
    fan_st = 1'b0;
    fan_drive_st = 1'b0;
    remote_off_seen = 1'b0;
    remote_off_at = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i])
      send_beat({dir_tbl[i].opcode, dir_tbl[i].now_ms, dir_tbl[i].pins},
                dir_tbl[i].checked, dir_tbl[i].status);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      mode = ph % 4;
      send_idle_pct = (mode == 1) ? 85 : (mode == 3) ? 31 : 0;
      recv_stall_pct = (mode == 2) ? 85 : (mode == 3) ? 31 : 0;
      n_items = (ph == 0) ? 150 : 295;
      if (ph > 0) begin
        // Registers only change once the pipeline has fully drained.
        in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        case (ph)
          1: begin
            write_register(REG_DEBOUNCE_MIN, '0);
            write_register(REG_LOCKOUT, '0);
            write_register(REG_PRIO_WINDOW, '0);
          end
          2: begin
            write_register(REG_DEBOUNCE_MIN, 20'd65535);
            write_register(REG_LOCKOUT, 20'd1000000);
            write_register(REG_PRIO_WINDOW, 20'd1000000);
          end
          5: begin
            write_register(REG_DEBOUNCE_MIN, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
            write_register(REG_LOCKOUT, CFG_DATA_W'($urandom_range(0, 20'hFFFFF)));
            write_register(REG_PRIO_WINDOW, CFG_DATA_W'($urandom_range(0, 20'hFFFFF)));
            write_register(REG_SPARE, 20'hFFFFF);
          end
          default: begin
            write_register(REG_DEBOUNCE_MIN, CFG_DATA_W'($urandom_range(0, 40)));
            write_register(REG_LOCKOUT, CFG_DATA_W'($urandom_range(0, 400)));
            write_register(REG_PRIO_WINDOW, CFG_DATA_W'($urandom_range(0, 3000)));
          end
        endcase
        cfg_wr_en <= 1'b0;
      end
      // Long receiver stall while beats keep coming, to back up the input.
      if (ph == 4) hold_left = HOLD_OFF_CYCLES;
      repeat (n_items) begin
        make_random_beat(b);
        send_beat(b, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d beats with %0d results checked: %0d light and %0d fan presses counted.",
             n_beats, n_results, n_light_presses, n_fan_presses);
    $display("Covered %0d register settings, zero to full scale, under idle and stall mixes.",
             NUM_PHASES);
    if (n_errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    logic [4:0] got;
    logic [4:0] want;
    if (!rst && out_valid && out_ready) begin
      got = {lamp_on, fan_on, fan_drive, light_press_seen, fan_press_seen};
      if (pending_status.size() == 0) begin
        $error("result beat arrived with no prediction pending");
        n_errors++;
      end else begin
        want = pending_status.pop_front();
        n_results++;
        for (int i = 0; i < 5; i++)
          if (got[i] !== want[i]) begin
            $error("%s: expected %0b, got %0b", field_name[i], want[i], got[i]);
            n_errors++;
          end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: sim.f
hdl/dtsc_pkg.sv
hdl/dtsc_debounce.sv
hdl/debounced_toggle_switch_controller_unit.sv
tb/tb_top.sv
